[sv/sphere_triangle_subdivider_defines.svh]
// Assertion macros shared by the sphere triangle subdivider RTL.
// Depends on nothing; the asserting module supplies clk and rst_n.
`ifndef SPHERE_TRIANGLE_SUBDIVIDER_DEFINES_SVH
`define SPHERE_TRIANGLE_SUBDIVIDER_DEFINES_SVH

// Checked only out of reset.
`define STS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sts assertion failed");

// Checked at every edge, reset included.
`define STS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("sts assertion failed");

`endif

[sv/sts_pkg.sv]
// Package for the sphere triangle subdivider: sequencer states, constants,
// output order table. Used by sphere_triangle_subdivider.
`timescale 1ns / 1ps
package sts_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_W = 24;
    localparam int RADIUS_W = 23;
    localparam int INDEX_W = 32;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd65536;
    localparam logic [2:0] ADDR_RADIUS = 3'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMUL,
        ST_CWR,
        ST_MINIT,
        ST_SQMUL,
        ST_SQACC,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_DINIT,
        ST_DIV,
        ST_DMUL,
        ST_DWR,
        ST_EMIT
    } sts_state_t;

    // Vertex slots: 0..2 corners, 3 = m02, 4 = m01, 5 = m12.
    function automatic logic [2:0] sts_order(input logic [3:0] k);
        logic [2:0] r;
        case (k)
            4'd0: r = 3'd4;
            4'd1: r = 3'd1;
            4'd2: r = 3'd5;
            4'd3: r = 3'd0;
            4'd4: r = 3'd4;
            4'd5: r = 3'd3;
            4'd6: r = 3'd3;
            4'd7: r = 3'd4;
            4'd8: r = 3'd5;
            4'd9: r = 3'd3;
            4'd10: r = 3'd5;
            4'd11: r = 3'd2;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] sts_mid_a(input logic [1:0] m);
        return (m == 2'd2) ? 3'd1 : 3'd0;
    endfunction

    function automatic logic [2:0] sts_mid_b(input logic [1:0] m);
        return (m == 2'd1) ? 3'd1 : 3'd2;
    endfunction

endpackage

[sv/sphere_triangle_subdivider.sv]
// Sphere triangle subdivider top level: corner intake, shared multiplier,
// bit-serial square root and divider, emission. Depends on sts_pkg.
//
// Usage: corners arrive on the in channel (valid/ready), one request per
// corner. The first two corners of a triangle are stored as they are taken.
// The third starts the sequencer; in_ready stays low until all twelve
// vertices have been taken from the out channel (valid/ready), the twelfth
// with last_of_triangle set. out_vertex_index counts emitted vertices.
// From the third corner to the first vertex the sequencer runs
// 9 corner scalings on the multiplier, then per midpoint three squares,
// a 32-step square root and three (FRAC_BITS+2)-step divides, each
// followed by one radius multiply. A zero-length midpoint skips its
// root and divides. Emission then gives one vertex per cycle while
// out_ready is high; a stall holds the vertex.
// Reset (rst_n low, asynchronous) clears the sequencer, the corner count
// and the vertex index and sets the radius to 1.0. The user must write
// the radius through the APB port at address 0 only while the block is
// idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`include "sphere_triangle_subdivider_defines.svh"
module sphere_triangle_subdivider #(
    parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [23:0] corner_normal_x,
    input  logic signed [23:0] corner_normal_y,
    input  logic signed [23:0] corner_normal_z,
    input  logic signed [23:0] corner_tex_u,
    input  logic signed [23:0] corner_tex_v,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [23:0] out_pos_x,
    output logic signed [23:0] out_pos_y,
    output logic signed [23:0] out_pos_z,
    output logic signed [23:0] out_normal_x,
    output logic signed [23:0] out_normal_y,
    output logic signed [23:0] out_normal_z,
    output logic signed [23:0] out_tex_u,
    output logic signed [23:0] out_tex_v,
    output logic [31:0] out_vertex_index,
    output logic last_of_triangle
);

    localparam int QW = FRAC_BITS + 2;
    localparam int NW = FRAC_BITS + 33;

    sts_pkg::sts_state_t state_reg, state_next;

    logic [1:0] slot_reg;
    logic [31:0] count_reg;
    logic [22:0] radius_reg;
    logic [2:0] vi_reg;
    logic [1:0] ci_reg;
    logic [3:0] k_reg;
    logic [5:0] iter_reg;

    logic signed [23:0] nrm_reg [6][3];
    logic signed [23:0] pos_reg [6][3];
    logic signed [23:0] tex_reg [6][2];
    logic signed [24:0] s_reg [3];
    logic [49:0] acc_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [32:0] rem_reg;
    logic [QW-1:0] lo_reg;
    logic signed [51:0] prod_reg;

    logic in_acc, out_acc, cfg_wr;
    logic signed [25:0] mul_a, mul_b;
    logic signed [51:0] prod;
    logic signed [51:0] rnd;
    logic signed [51:0] shifted;
    logic signed [23:0] scaled;
    logic [2:0] mid_a, mid_b, ord;
    logic [2:0] slot_idx;
    logic [63:0] root_bit, root_t;
    logic [24:0] mag;
    logic [NW-1:0] num;
    logic [33:0] div_r2, div_d;
    logic [63:0] q64;
    logic signed [24:0] qneg;
    logic signed [23:0] qsat;
    logic signed [24:0] tsum_u, tsum_v;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == sts_pkg::ADDR_RADIUS);
    assign prdata = (paddr == sts_pkg::ADDR_RADIUS) ? {9'd0, radius_reg} : 32'd0;

    assign in_acc = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    assign mid_a = sts_pkg::sts_mid_a(vi_reg[1:0]);
    assign mid_b = sts_pkg::sts_mid_b(vi_reg[1:0]);
    assign ord = sts_pkg::sts_order(k_reg);
    assign slot_idx = {1'b0, slot_reg};

    // Saturated midpoint normal component from the quotient.
    assign q64 = 64'(lo_reg);
    assign qneg = -$signed({1'b0, (q64 > 64'd8388608) ? 24'd8388608 : q64[23:0]});
    always_comb
    begin
        if (s_reg[ci_reg] < 0)
            qsat = qneg[23:0];
        else
            qsat = (q64 > 64'd8388607) ? 24'sd8388607 : $signed(q64[23:0]);
    end

    // Shared multiplier.
    always_comb
    begin
        mul_b = $signed({3'd0, radius_reg});
        case (state_reg)
            sts_pkg::ST_CMUL: mul_a = 26'(nrm_reg[vi_reg][ci_reg]);
            sts_pkg::ST_SQMUL:
            begin
                mul_a = 26'(s_reg[ci_reg]);
                mul_b = 26'(s_reg[ci_reg]);
            end
            sts_pkg::ST_DMUL: mul_a = 26'(qsat);
            default: mul_a = 26'sd0;
        endcase
    end
    assign prod = mul_a * mul_b;

    // Round to nearest, floor, saturate.
    assign rnd = prod_reg + (52'sd1 <<< (FRAC_BITS - 1));
    assign shifted = rnd >>> FRAC_BITS;
    assign scaled = (shifted > 52'sd8388607) ? 24'sd8388607 :
                    (shifted < -52'sd8388608) ? -24'sd8388608 : shifted[23:0];

    assign root_bit = 64'h4000_0000_0000_0000 >> {iter_reg[4:0], 1'b0};
    assign root_t = res_reg + root_bit;

    assign mag = s_reg[ci_reg][24] ? 25'(-s_reg[ci_reg]) : 25'(s_reg[ci_reg]);
    assign num = (NW'(mag) << (FRAC_BITS + 7)) + NW'(res_reg[31:0]);
    assign div_r2 = {rem_reg, lo_reg[QW-1]};
    assign div_d = {1'b0, res_reg[31:0], 1'b0};

    assign tsum_u = 25'(tex_reg[mid_a][0]) + 25'(tex_reg[mid_b][0]);
    assign tsum_v = 25'(tex_reg[mid_a][1]) + 25'(tex_reg[mid_b][1]);

    assign in_ready = (state_reg == sts_pkg::ST_IDLE);
    assign out_valid = (state_reg == sts_pkg::ST_EMIT);
    assign out_pos_x = pos_reg[ord][0];
    assign out_pos_y = pos_reg[ord][1];
    assign out_pos_z = pos_reg[ord][2];
    assign out_normal_x = nrm_reg[ord][0];
    assign out_normal_y = nrm_reg[ord][1];
    assign out_normal_z = nrm_reg[ord][2];
    assign out_tex_u = tex_reg[ord][0];
    assign out_tex_v = tex_reg[ord][1];
    assign out_vertex_index = count_reg + 32'(k_reg);
    assign last_of_triangle = out_valid && (k_reg == 4'd11);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sts_pkg::ST_IDLE:
                if (in_acc && slot_reg == 2'd2)
                    state_next = sts_pkg::ST_CMUL;
            sts_pkg::ST_CMUL: state_next = sts_pkg::ST_CWR;
            sts_pkg::ST_CWR:
                if (vi_reg == 3'd2 && ci_reg == 2'd2)
                    state_next = sts_pkg::ST_MINIT;
                else
                    state_next = sts_pkg::ST_CMUL;
            sts_pkg::ST_MINIT: state_next = sts_pkg::ST_SQMUL;
            sts_pkg::ST_SQMUL: state_next = sts_pkg::ST_SQACC;
            sts_pkg::ST_SQACC:
                state_next = (ci_reg == 2'd2) ? sts_pkg::ST_ROOT_INIT : sts_pkg::ST_SQMUL;
            sts_pkg::ST_ROOT_INIT:
                if (acc_reg != 50'd0)
                    state_next = sts_pkg::ST_ROOT;
                else if (vi_reg == 3'd2)
                    state_next = sts_pkg::ST_EMIT;
                else
                    state_next = sts_pkg::ST_MINIT;
            sts_pkg::ST_ROOT:
                if (iter_reg == 6'd31)
                    state_next = sts_pkg::ST_DINIT;
            sts_pkg::ST_DINIT: state_next = sts_pkg::ST_DIV;
            sts_pkg::ST_DIV:
                if (iter_reg == 6'(QW - 1))
                    state_next = sts_pkg::ST_DMUL;
            sts_pkg::ST_DMUL: state_next = sts_pkg::ST_DWR;
            sts_pkg::ST_DWR:
                if (ci_reg != 2'd2)
                    state_next = sts_pkg::ST_DINIT;
                else if (vi_reg == 3'd2)
                    state_next = sts_pkg::ST_EMIT;
                else
                    state_next = sts_pkg::ST_MINIT;
            sts_pkg::ST_EMIT:
                if (out_acc && k_reg == 4'd11)
                    state_next = sts_pkg::ST_IDLE;
            default: state_next = sts_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sts_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Control counters and the radius register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 2'd0;
            count_reg <= 32'd0;
            radius_reg <= sts_pkg::RADIUS_RESET;
            vi_reg <= 3'd0;
            ci_reg <= 2'd0;
            k_reg <= 4'd0;
            iter_reg <= 6'd0;
        end
        else
        begin
            if (cfg_wr)
                radius_reg <= pwdata[22:0];
            case (state_reg)
                sts_pkg::ST_IDLE:
                begin
                    vi_reg <= 3'd0;
                    ci_reg <= 2'd0;
                    k_reg <= 4'd0;
                    if (in_acc && slot_reg != 2'd2)
                        slot_reg <= slot_reg + 2'd1;
                end
                sts_pkg::ST_CWR:
                    if (ci_reg == 2'd2)
                    begin
                        ci_reg <= 2'd0;
                        vi_reg <= (vi_reg == 3'd2) ? 3'd0 : vi_reg + 3'd1;
                    end
                    else
                        ci_reg <= ci_reg + 2'd1;
                sts_pkg::ST_MINIT: ci_reg <= 2'd0;
                sts_pkg::ST_SQACC:
                    ci_reg <= (ci_reg == 2'd2) ? 2'd0 : ci_reg + 2'd1;
                sts_pkg::ST_ROOT_INIT:
                begin
                    iter_reg <= 6'd0;
                    if (acc_reg == 50'd0)
                        vi_reg <= vi_reg + 3'd1;
                end
                sts_pkg::ST_ROOT:
                    iter_reg <= (iter_reg == 6'd31) ? 6'd0 : iter_reg + 6'd1;
                sts_pkg::ST_DINIT: iter_reg <= 6'd0;
                sts_pkg::ST_DIV: iter_reg <= iter_reg + 6'd1;
                sts_pkg::ST_DWR:
                    if (ci_reg == 2'd2)
                    begin
                        ci_reg <= 2'd0;
                        vi_reg <= vi_reg + 3'd1;
                    end
                    else
                        ci_reg <= ci_reg + 2'd1;
                sts_pkg::ST_EMIT:
                    if (out_acc)
                    begin
                        if (k_reg == 4'd11)
                        begin
                            k_reg <= 4'd0;
                            slot_reg <= 2'd0;
                            count_reg <= count_reg + 32'd12;
                        end
                        else
                            k_reg <= k_reg + 4'd1;
                    end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            sts_pkg::ST_IDLE:
                if (in_acc)
                begin
                    nrm_reg[slot_idx][0] <= corner_normal_x;
                    nrm_reg[slot_idx][1] <= corner_normal_y;
                    nrm_reg[slot_idx][2] <= corner_normal_z;
                    tex_reg[slot_idx][0] <= corner_tex_u;
                    tex_reg[slot_idx][1] <= corner_tex_v;
                end
            sts_pkg::ST_CMUL: prod_reg <= prod;
            sts_pkg::ST_CWR: pos_reg[vi_reg][ci_reg] <= scaled;
            sts_pkg::ST_MINIT:
            begin
                for (int i = 0; i < 3; i++)
                    s_reg[i] <= 25'(pos_reg[mid_a][i]) + 25'(pos_reg[mid_b][i]);
                tex_reg[3'd3 + vi_reg][0] <= tsum_u[24:1];
                tex_reg[3'd3 + vi_reg][1] <= tsum_v[24:1];
                acc_reg <= 50'd0;
            end
            sts_pkg::ST_SQMUL: prod_reg <= prod;
            sts_pkg::ST_SQACC: acc_reg <= acc_reg + prod_reg[49:0];
            sts_pkg::ST_ROOT_INIT:
            begin
                x_reg <= {2'd0, acc_reg, 12'd0};
                res_reg <= 64'd0;
                if (acc_reg == 50'd0)
                    for (int i = 0; i < 3; i++)
                    begin
                        nrm_reg[3'd3 + vi_reg][i] <= 24'sd0;
                        pos_reg[3'd3 + vi_reg][i] <= 24'sd0;
                    end
            end
            sts_pkg::ST_ROOT:
                if (x_reg >= root_t)
                begin
                    x_reg <= x_reg - root_t;
                    res_reg <= (res_reg >> 1) + root_bit;
                end
                else
                    res_reg <= res_reg >> 1;
            sts_pkg::ST_DINIT:
            begin
                rem_reg <= 33'(num >> QW);
                lo_reg <= num[QW-1:0];
            end
            sts_pkg::ST_DIV:
                if (div_r2 >= div_d)
                begin
                    rem_reg <= 33'(div_r2 - div_d);
                    lo_reg <= {lo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_r2[32:0];
                    lo_reg <= {lo_reg[QW-2:0], 1'b0};
                end
            sts_pkg::ST_DMUL:
            begin
                nrm_reg[3'd3 + vi_reg][ci_reg] <= qsat;
                prod_reg <= prod;
            end
            sts_pkg::ST_DWR: pos_reg[3'd3 + vi_reg][ci_reg] <= scaled;
            default: ;
        endcase
    end

    `STS_ASSERT(a_no_overlap, !(in_ready && out_valid))
    `STS_ASSERT(a_slot_range, slot_reg != 2'd3)
    `STS_ASSERT(a_third_starts, in_acc && slot_reg == 2'd2 |=> !in_ready)
    `STS_ASSERT(a_last_frees, out_acc && last_of_triangle |=> in_ready && slot_reg == 2'd0)

endmodule

[test/tb_top.sv]
// Self-checking bench for sphere_triangle_subdivider: random and directed corners
// against a built-in fixed-point predictor. Depends on sts_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;

    typedef struct packed {
        logic [23:0] px, py, pz, nx, ny, nz, tu, tv;
        logic [31:0] idx;
        logic        last;
    } vertex_t;

    typedef struct {
        longint p[3];
        longint n[3];
        longint t[2];
    } point_t;

    class subdivision_board;
        localparam int F = 16;
        vertex_t     pending_vertices[$];
        longint      radius = 65536;
        longint      held_n[2][3];
        longint      held_t[2][2];
        int          slot = 0;
        logic [31:0] vertex_count = 0;
        int          errors = 0;

        function longint clamp24(longint v);
            return v > 8388607 ? 8388607 : (v < -8388608 ? -8388608 : v);
        endfunction

        function longint on_sphere(longint n);
            return clamp24((n * radius + (64'sd1 <<< (F - 1))) >>> F);
        endfunction

        function longint unsigned root(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function void midpoint(input point_t a, input point_t b, output point_t m);
            longint s[3];
            longint unsigned sq, len, mag, q;
            longint v;
            sq = 0;
            for (int i = 0; i < 3; i++)
            begin
                s[i] = a.p[i] + b.p[i];
                sq += s[i] * s[i];
            end
            for (int i = 0; i < 2; i++) m.t[i] = (a.t[i] + b.t[i]) >>> 1;
            if (sq == 0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m.n[i] = 0;
                    m.p[i] = 0;
                end
                return;
            end
            len = root(sq << 12);
            for (int i = 0; i < 3; i++)
            begin
                mag = s[i] < 0 ? -s[i] : s[i];
                q = ((mag << (F + 7)) + len) / (2 * len);
                v = q > 8388608 ? 8388608 : longint'(q);
                m.n[i] = clamp24(s[i] < 0 ? -v : v);
                m.p[i] = on_sphere(m.n[i]);
            end
        endfunction

        function void set_radius(logic [31:0] value);
            radius = longint'(value[22:0]);
        endfunction

        function void note_corner(logic signed [23:0] nx, ny, nz, tu, tv);
            point_t pt[6];
            int order[12] = '{4, 1, 5, 0, 4, 3, 3, 4, 5, 3, 5, 2};
            vertex_t e;
            if (slot < 2)
            begin
                held_n[slot] = '{longint'(nx), longint'(ny), longint'(nz)};
                held_t[slot] = '{longint'(tu), longint'(tv)};
                slot++;
                return;
            end
            for (int c = 0; c < 3; c++)
            begin
                if (c < 2)
                begin
                    pt[c].n = held_n[c];
                    pt[c].t = held_t[c];
                end
                else
                begin
                    pt[c].n = '{longint'(nx), longint'(ny), longint'(nz)};
                    pt[c].t = '{longint'(tu), longint'(tv)};
                end
                for (int i = 0; i < 3; i++) pt[c].p[i] = on_sphere(pt[c].n[i]);
            end
            midpoint(pt[0], pt[2], pt[3]);
            midpoint(pt[0], pt[1], pt[4]);
            midpoint(pt[1], pt[2], pt[5]);
            for (int k = 0; k < 12; k++)
            begin
                point_t w;
                w = pt[order[k]];
                e.px = 24'(w.p[0]); e.py = 24'(w.p[1]); e.pz = 24'(w.p[2]);
                e.nx = 24'(w.n[0]); e.ny = 24'(w.n[1]); e.nz = 24'(w.n[2]);
                e.tu = 24'(w.t[0]); e.tv = 24'(w.t[1]);
                e.idx = vertex_count + 32'(k);
                e.last = (k == 11);
                pending_vertices = {pending_vertices, e};
            end
            vertex_count += 32'd12;
            slot = 0;
        endfunction

        function void check_vertex(vertex_t got);
            vertex_t want;
            if (pending_vertices.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected vertex %p", got);
                return;
            end
            want = pending_vertices.pop_front();
            if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz ||
                got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
                got.tu !== want.tu || got.tv !== want.tv ||
                got.idx !== want.idx || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("vertex mismatch\n  expected %p\n  actual   %p", want, got);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 0;
    logic in_ready;
    logic signed [23:0] corner_normal_x = 0, corner_normal_y = 0, corner_normal_z = 0;
    logic signed [23:0] corner_tex_u = 0, corner_tex_v = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [23:0] out_pos_x, out_pos_y, out_pos_z;
    logic signed [23:0] out_normal_x, out_normal_y, out_normal_z;
    logic signed [23:0] out_tex_u, out_tex_v;
    logic [31:0] out_vertex_index;
    logic last_of_triangle;

    int send_idle = 17;
    int recv_idle = 51;
    bit hold_output = 0;
    subdivision_board board = new();

    sphere_triangle_subdivider dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Output side: random back-pressure, plus the long hold-off.
    initial
    begin
        forever
        begin
            out_ready <= !hold_output && ($urandom_range(99) >= recv_idle);
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_vertex({out_pos_x, out_pos_y, out_pos_z, out_normal_x,
                                    out_normal_y, out_normal_z, out_tex_u, out_tex_v,
                                    out_vertex_index, last_of_triangle});
        end
    end

    task automatic write_radius(logic [31:0] value);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= sts_pkg::ADDR_RADIUS; pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.set_radius(value);
    endtask

    task automatic send_corner(logic [23:0] nx, ny, nz, tu, tv);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        corner_normal_x <= nx; corner_normal_y <= ny; corner_normal_z <= nz;
        corner_tex_u <= tu; corner_tex_v <= tv;
        do @(posedge clk); while (!in_ready);
        board.note_corner(nx, ny, nz, tu, tv);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending_vertices.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [23:0] pick_normal();
        int mode;
        mode = $urandom_range(9);
        case (mode)
            0, 1, 2, 3, 4, 5: return 24'($signed($urandom_range(131072)) - 65536);
            6: return 24'($urandom);
            7:
            begin
                case ($urandom_range(4))
                    0: return 24'h7fffff;
                    1: return 24'h800000;
                    2: return 24'h000001;
                    3: return 24'hffffff;
                    default: return 24'h000000;
                endcase
            end
            8: return 24'h000000;
            default: return 24'($signed($urandom_range(8)) - 4);
        endcase
    endfunction

    function automatic logic [23:0] pick_tex();
        return $urandom_range(7) == 0 ? ($urandom_range(1) ? 24'h7fffff : 24'h800000)
                                      : 24'($urandom);
    endfunction

    task automatic random_triangles(int count);
        repeat (count)
            repeat (3) send_corner(pick_normal(), pick_normal(), pick_normal(),
                                   pick_tex(), pick_tex());
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: axes, opposite corners, extremes, zero and tiny normals.
        write_radius(32'd65536);
        send_corner(24'h010000, 0, 0, 24'h7fffff, 24'h800000);
        send_corner(0, 24'h010000, 0, 24'h800000, 24'h7fffff);
        send_corner(0, 0, 24'h010000, 0, 24'hffffff);
        send_corner(24'h010000, 0, 0, 1, 1);
        send_corner(0, 24'hff0000, 0, 3, 5);
        send_corner(24'hff0000, 0, 0, 24'hffffff, 24'hfffffe);
        send_corner(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
        send_corner(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
        send_corner(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
        send_corner(0, 0, 0, 0, 0);
        send_corner(0, 0, 0, 24'h555555, 24'haaaaaa);
        send_corner(0, 0, 0, 24'haaaaaa, 24'h555555);
        send_corner(1, 0, 24'hffffff, 2, 3);
        send_corner(24'hffffff, 0, 1, 4, 5);
        send_corner(2, 3, 24'hfffffd, 6, 7);
        send_corner(24'h00b505, 24'h00b505, 0, 0, 0);
        send_corner(24'hff4afb, 24'hff4afb, 0, 1, 0);
        send_corner(0, 0, 24'h800000, 0, 1);
        drain();

        // Zero radius: bit 23 and above dropped.
        write_radius(32'h00800000);
        random_triangles(2);
        drain();

        write_radius(32'd8388607);
        send_idle = 17;
        recv_idle = 51;
        fork
            begin
                hold_output = 1;
                repeat (1500) @(posedge clk);
                hold_output = 0;
            end
            random_triangles(46);
        join
        drain();

        write_radius(32'd1);
        send_idle = 51;
        recv_idle = 17;
        random_triangles(10);
        drain();

        write_radius(32'($urandom_range(8388607, 1)));
        random_triangles(36);
        drain();

        write_radius(32'd65536);
        send_idle = 0;
        recv_idle = 0;
        random_triangles(46);
        drain();

        repeat (400) @(posedge clk);
        if (board.errors == 0 && board.pending_vertices.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
